// ----- rtl/pla_pkg.sv -----
// shared types and constants for the packed lane alu
package pla_pkg;

  localparam int unsigned VectorBits   = 128;
  localparam int unsigned WideLaneBits = 8;
  localparam int unsigned NumWideLanes = VectorBits / WideLaneBits;
  localparam int unsigned DivSteps     = WideLaneBits;

  typedef enum logic [2:0] {
    OpAdd = 3'd0,
    OpSub = 3'd1,
    OpMul = 3'd2,
    OpDiv = 3'd3,
    OpRem = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    RegLaneWidth = 2'd0,
    RegLaneCount = 2'd1
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] a_low;
    logic [63:0] a_high;
    logic [63:0] b_low;
    logic [63:0] b_high;
  } req_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic        unsupported;
  } rsp_t;

endpackage

// ----- rtl/pla_stream_if.sv -----
// valid/ready channel carrying one payload type
interface pla_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/packed_lane_alu_unit.sv -----
// packed lane alu: pipelined add/sub/mul/div/rem over a 128-bit vector
//
//  channel | direction | payload
//  req     | in        | operation, a_low, a_high, b_low, b_high
//  rsp     | out       | result_low, result_high, unsupported
//  cfg     | in        | cfg_we_i, cfg_idx_i, cfg_data_i
//
// eleven register stages between a request transfer and its valid result
// one transfer per cycle on each side when the receiver keeps up
// stages: decode and masks, add/sub and multiply, eight restoring division steps, result
// the whole pipe advances together; a stalled result holds every stage
// reset clears valid bits and sets lane_width 4, lane_count 32
module packed_lane_alu_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  pla_stream_if.sink   req,
  pla_stream_if.source rsp
);

  localparam int unsigned NL = pla_pkg::NumWideLanes;
  localparam int unsigned WL = pla_pkg::WideLaneBits;
  localparam int unsigned VB = pla_pkg::VectorBits;
  localparam int unsigned NS = pla_pkg::DivSteps;

  logic [3:0] lane_width_q;
  logic [7:0] lane_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_width_q <= 4'd4;
      lane_count_q <= 8'd32;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == pla_pkg::RegLaneWidth) lane_width_q <= cfg_data_i[3:0];
      else if (cfg_idx_i == pla_pkg::RegLaneCount) lane_count_q <= cfg_data_i;
    end
  end

  logic advance;
  logic [NS+2:0] vld_q;
  assign advance   = !vld_q[NS+2] || rsp.ready;
  assign req.ready = advance;

  // stage 0: decode, lane masks
  logic [VB-1:0] a_in, b_in, a0_q, b0_q, top_q, used_q;
  logic [2:0]    op0_q;
  logic          bad0_q;
  logic [11:0]   total;
  logic [VB-1:0] top_d, used_d;
  logic          bad_d;

  assign a_in  = {req.payload.a_high, req.payload.a_low};
  assign b_in  = {req.payload.b_high, req.payload.b_low};
  assign total = 12'(lane_width_q) * 12'(lane_count_q);

  always_comb begin
    top_d  = '0;
    used_d = '0;
    for (int k = 0; k < VB; k++) begin
      used_d[k] = (12'(k) < total);
    end
    for (int j = 1; j <= 15; j++) begin
      if (4'(j) == lane_width_q) begin
        for (int k = j - 1; k < VB; k += j) begin
          top_d[k] = used_d[k];
        end
      end
    end
    bad_d = 1'b0;
    if (req.payload.operation == pla_pkg::OpAdd ||
        req.payload.operation == pla_pkg::OpSub) begin
      bad_d = (lane_width_q == 4'd0) || (lane_count_q == 8'd0) || (total > 12'(VB));
    end else if (req.payload.operation > pla_pkg::OpRem) begin
      bad_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (advance) vld_q <= {vld_q[NS+1:0], req.valid};
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      a0_q   <= a_in;
      b0_q   <= b_in;
      top_q  <= top_d;
      used_q <= used_d;
      op0_q  <= req.payload.operation;
      bad0_q <= bad_d;
    end
  end

  // stage 1: add/sub and multiply, division setup
  logic [VB-1:0] as_d;
  logic [VB-1:0] mul_d;
  logic [VB-1:0] low_m, sa, sb, sum;
  assign low_m = used_q & ~top_q;
  always_comb begin
    sa = a0_q & low_m;
    sb = b0_q & low_m;
    if (op0_q == pla_pkg::OpAdd) begin
      sum  = sa + sb;
      as_d = (sum & low_m) | ((sum ^ a0_q ^ b0_q) & top_q);
    end else begin
      sum  = (sa | top_q) - sb;
      as_d = (sum & low_m) | ((sum ^ a0_q ^ b0_q ^ top_q) & top_q);
    end
    for (int l = 0; l < NL; l++) begin
      mul_d[l*WL +: WL] = WL'(a0_q[l*WL +: WL] * b0_q[l*WL +: WL]);
    end
  end

  logic [2:0]    op_q [NS+1];
  logic          bad_q [NS+1];
  logic [VB-1:0] rem_q [NS+1];
  logic [VB-1:0] quo_q [NS+1];
  logic [VB-1:0] dvs_q [NS+1];
  logic [VB-1:0] pre_q [NS+1];

  always_ff @(posedge clk_i) begin
    if (advance) begin
      op_q[0]   <= op0_q;
      bad_q[0]  <= bad0_q;
      rem_q[0]  <= '0;
      quo_q[0]  <= a0_q;
      dvs_q[0]  <= b0_q;
      pre_q[0]  <= (op0_q == pla_pkg::OpMul) ? mul_d : as_d;
    end
  end

  // stages 2..9: one restoring step per stage across all lanes
  for (genvar s = 0; s < NS; s++) begin : g_div
    logic [VB-1:0] rem_d, quo_d;
    always_comb begin
      for (int l = 0; l < NL; l++) begin
        logic [WL:0] t;
        t = {rem_q[s][l*WL +: WL], quo_q[s][l*WL+WL-1]};
        if (t >= {1'b0, dvs_q[s][l*WL +: WL]}) begin
          t = t - {1'b0, dvs_q[s][l*WL +: WL]};
          quo_d[l*WL +: WL] = {quo_q[s][l*WL +: WL-1], 1'b1};
        end else begin
          quo_d[l*WL +: WL] = {quo_q[s][l*WL +: WL-1], 1'b0};
        end
        rem_d[l*WL +: WL] = t[WL-1:0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (advance) begin
        rem_q[s+1] <= rem_d;
        quo_q[s+1] <= quo_d;
        dvs_q[s+1] <= dvs_q[s];
        op_q[s+1]  <= op_q[s];
        bad_q[s+1] <= bad_q[s];
        pre_q[s+1] <= pre_q[s];
      end
    end
  end

  // final stage: select and register result
  logic [VB-1:0] res_d;
  always_comb begin
    case (op_q[NS])
      pla_pkg::OpDiv: res_d = quo_q[NS];
      pla_pkg::OpRem: res_d = rem_q[NS];
      default:        res_d = pre_q[NS];
    endcase
    if (bad_q[NS]) res_d = '0;
  end

  pla_pkg::rsp_t out_q;
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.result_low  <= res_d[63:0];
      out_q.result_high <= res_d[VB-1:64];
      out_q.unsupported <= bad_q[NS];
    end
  end

  assign rsp.valid   = vld_q[NS+2];
  assign rsp.payload = out_q;

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.payload.unsupported |->
      rsp.payload.result_low == '0 && rsp.payload.result_high == '0)
    else $error("unsupported result not zero");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
    else $error("stalled result changed");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp.valid |-> req.ready)
    else $error("pipe stalled while output empty");

endmodule

// ----- sim/tb.sv -----
// self-checking testbench for packed_lane_alu_unit with a result scoreboard
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OpSpare5 = 3'd5;
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;
  localparam logic [1:0] RegSpare2 = 2'd2;
  localparam logic [1:0] RegSpare3 = 2'd3;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned PipeDepth = 11;

  class packed_result_book;
    bit [3:0] lane_width;
    bit [7:0] lane_count;
    pla_pkg::rsp_t due_results[$];
    int unsigned mismatches;

    function new();
      lane_width = 4;
      lane_count = 32;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] data);
      if (idx == pla_pkg::RegLaneWidth) lane_width = data[3:0];
      else if (idx == pla_pkg::RegLaneCount) lane_count = data;
    endfunction

    function pla_pkg::rsp_t packed_result(pla_pkg::req_t q);
      pla_pkg::rsp_t r;
      bit [127:0] a, b, m, x, y, z, acc;
      bit [7:0] xb, yb, zb;
      int unsigned w, n;
      a = {q.a_high, q.a_low};
      b = {q.b_high, q.b_low};
      acc = '0;
      r.unsupported = 1'b0;
      w = lane_width;
      n = lane_count;
      case (q.operation)
        pla_pkg::OpAdd, pla_pkg::OpSub: begin
          if (w == 0 || n == 0 || w * n > pla_pkg::VectorBits) begin
            r.unsupported = 1'b1;
          end else begin
            m = (128'd1 << w) - 1;
            for (int i = 0; i < n; i++) begin
              x = (a >> (i * w)) & m;
              y = (b >> (i * w)) & m;
              z = (q.operation == pla_pkg::OpAdd) ? x + y : x - y;
              acc |= (z & m) << (i * w);
            end
          end
        end
        pla_pkg::OpMul, pla_pkg::OpDiv, pla_pkg::OpRem: begin
          for (int i = 0; i < pla_pkg::NumWideLanes; i++) begin
            xb = a[i*8 +: 8];
            yb = b[i*8 +: 8];
            if (q.operation == pla_pkg::OpMul) zb = xb * yb;
            else if (yb == 0) zb = (q.operation == pla_pkg::OpDiv) ? 8'hff : xb;
            else zb = (q.operation == pla_pkg::OpDiv) ? xb / yb : xb % yb;
            acc[i*8 +: 8] = zb;
          end
        end
        default: r.unsupported = 1'b1;
      endcase
      r.result_low = acc[63:0];
      r.result_high = acc[127:64];
      return r;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      mismatches++;
    endtask

    function void note_request(pla_pkg::req_t q);
      due_results.push_back(packed_result(q));
    endfunction

    task check_result(pla_pkg::rsp_t got);
      pla_pkg::rsp_t want;
      if (due_results.size() == 0) begin
        report("unexpected transfer", got.result_low, 64'd0);
      end else begin
        want = due_results.pop_front();
        if (got.result_low !== want.result_low)
          report("result_low", got.result_low, want.result_low);
        if (got.result_high !== want.result_high)
          report("result_high", got.result_high, want.result_high);
        if (got.unsupported !== want.unsupported)
          report("unsupported", 64'(got.unsupported), 64'(want.unsupported));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_data_i;

  pla_stream_if #(.payload_t(pla_pkg::req_t)) req_if ();
  pla_stream_if #(.payload_t(pla_pkg::rsp_t)) rsp_if ();

  packed_lane_alu_unit DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req(req_if.sink),
    .rsp(rsp_if.source)
  );

  packed_result_book book = new();
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cycles;
  bit hold_request;
  int unsigned quiet_cycles;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // monitor: both channels sampled on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) book.note_request(req_if.payload);
      if (rsp_if.valid && rsp_if.ready) book.check_result(rsp_if.payload);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // receiver: random stalls plus a single long hold-off
  always @(negedge clk_i) begin
    if (hold_request && hold_cycles == 0) begin
      hold_cycles = 300;
      hold_request = 1'b0;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(pla_pkg::req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.payload <= q;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (book.due_results.size() != 0) @(negedge clk_i);
    repeat (PipeDepth + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    book.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand_half(int unsigned style);
    logic [63:0] v;
    for (int i = 0; i < 8; i++) begin
      case (style == 0 ? $urandom_range(3) : style)
        0: v[i*8 +: 8] = 8'h00;
        1: v[i*8 +: 8] = 8'hff;
        2: v[i*8 +: 8] = 8'(1 << $urandom_range(7));
        default: v[i*8 +: 8] = 8'($urandom);
      endcase
    end
    return v;
  endfunction

  function automatic pla_pkg::req_t rand_req();
    pla_pkg::req_t q;
    int unsigned style;
    case ($urandom_range(19))
      0: q.operation = 3'($urandom_range(5, 7));
      1, 2, 3, 4, 5: q.operation = pla_pkg::OpAdd;
      6, 7, 8, 9: q.operation = pla_pkg::OpSub;
      10, 11, 12: q.operation = pla_pkg::OpMul;
      13, 14, 15: q.operation = pla_pkg::OpDiv;
      default: q.operation = pla_pkg::OpRem;
    endcase
    style = ($urandom_range(3) == 0) ? 0 : 3;
    q.a_low = rand_half(style);
    q.a_high = rand_half(style);
    q.b_low = rand_half(style);
    q.b_high = rand_half(style);
    return q;
  endfunction

  function automatic pla_pkg::req_t mk(logic [2:0] op, logic [127:0] a, logic [127:0] b);
    pla_pkg::req_t q;
    q.operation = op;
    {q.a_high, q.a_low} = a;
    {q.b_high, q.b_low} = b;
    return q;
  endfunction

  logic [7:0] widths[10] = '{8'd1, 8'd15, 8'd8, 8'd15, 8'd0, 8'd3, 8'd2, 8'd1, 8'd7, 8'hf4};
  logic [7:0] counts[10] = '{8'd128, 8'd8, 8'd16, 8'd9, 8'd20, 8'd43, 8'd64, 8'd1, 8'd0, 8'd255};

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = pla_pkg::RegLaneWidth;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    rsp_if.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    hold_request = 1'b0;
    quiet_cycles = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset shape: 32 lanes of 4 bits
    send_item(mk(pla_pkg::OpAdd, '1, {32{4'h1}}));
    send_item(mk(pla_pkg::OpSub, '0, {32{4'h1}}));
    send_item(mk(pla_pkg::OpAdd, {32{4'h8}}, {32{4'h8}}));
    send_item(mk(pla_pkg::OpSub, {32{4'h7}}, {32{4'h8}}));
    send_item(mk(pla_pkg::OpAdd, '0, '0));
    send_item(mk(pla_pkg::OpMul, '1, '1));
    send_item(mk(pla_pkg::OpMul, {16{8'h10}}, {16{8'h10}}));
    send_item(mk(pla_pkg::OpMul, {16{8'h80}}, {16{8'h03}}));
    send_item(mk(pla_pkg::OpDiv, '1, '0));
    send_item(mk(pla_pkg::OpDiv, '1, {16{8'h01}}));
    send_item(mk(pla_pkg::OpDiv, {16{8'h07}}, '1));
    send_item(mk(pla_pkg::OpDiv, {16{8'hc8}}, {16{8'h07}}));
    send_item(mk(pla_pkg::OpRem, {16{8'h5a}}, '0));
    send_item(mk(pla_pkg::OpRem, '1, {16{8'h10}}));
    send_item(mk(pla_pkg::OpRem, {16{8'h07}}, {16{8'h09}}));
    send_item(mk(OpSpare5, '1, '1));
    send_item(mk(OpSpare6, '1, '1));
    send_item(mk(OpSpare7, '1, '1));
    drain();

    write_reg(RegSpare2, 8'h33);
    write_reg(RegSpare3, 8'hff);
    send_item(mk(pla_pkg::OpAdd, '1, {32{4'h1}}));
    drain();

    for (int p = 0; p < 10; p++) begin
      write_reg(pla_pkg::RegLaneWidth, widths[p]);
      write_reg(pla_pkg::RegLaneCount, counts[p]);
      send_idle_pct = (p % 4 == 1) ? 61 : (p % 4 == 3) ? 32 : 0;
      recv_stall_pct = (p % 4 == 2) ? 61 : (p % 4 == 3) ? 32 : 0;
      if (p == 2) hold_request = 1'b1;
      send_item(mk(pla_pkg::OpAdd, '1, '1));
      send_item(mk(pla_pkg::OpSub, '0, '1));
      for (int k = 0; k < 136; k++) send_item(rand_req());
      drain();
    end

    recv_stall_pct = 0;
    repeat (PipeDepth + 4) @(negedge clk_i);
    if (book.mismatches == 0 && book.due_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
